>>> rtl/core/sidta_pkg.sv
package sidta_pkg;

   // Character field widths of a result
   localparam int CHAR_W  = 6;
   localparam int LEN_W   = 4;
   localparam int DIGIT_W = 4;

   // Magnitude bits consumed by one conversion stage
   localparam int STEP_BITS = 8;

   // Character codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

   // Decimal digits needed for the largest magnitude, 2**(bits-1)
   function automatic int calc_digits(input int bits);
      logic [64:0] lim;
      logic [67:0] pwr;
      int          n;
      lim = 65'd1 << (bits - 1);
      pwr = 68'd10;
      n   = 1;
      for (int k = 0; k < 20; k++) begin
         if (pwr <= 68'(lim)) begin
            n   = n + 1;
            pwr = pwr * 68'd10;
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/core/signed_int_to_decimal_ascii_top.sv
// Pipeline: a request passes the input register, one double-dabble stage per 8 bits,
// the digit count stage and the character register before it reaches the result port.
// Throughput: one character per cycle while rsp_ready is high; a number holds the result
// port for text_length characters (1 to 11 at 32 bits), set by the single character
// output register.
// Reset clears every stage valid bit and the output busy and minus flags; payloads are not reset.
module signed_int_to_decimal_ascii_top
   import sidta_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_char_code,
   output logic [LEN_W-1:0]      rsp_text_length,
   output logic                  rsp_is_last
);

   localparam int NDIG     = calc_digits(VALUE_BITS);
   localparam int NSTG     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS = NSTG * STEP_BITS;
   localparam int BCD_W    = NDIG * DIGIT_W;
   localparam int POS_W    = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int TOT_W    = $clog2(NDIG + 2);

   // Input register
   logic                  in0_valid_ff;
   logic                  in0_neg_ff;
   logic [PAD_BITS-1:0]   in0_mag_ff;
   logic [VALUE_BITS-1:0] in0_abs;

   // Conversion pipeline links
   logic                  stg_valid [NSTG+1];
   logic                  stg_ready [NSTG+1];
   logic                  stg_neg   [NSTG+1];
   logic [BCD_W-1:0]      stg_bcd   [NSTG+1];
   logic [PAD_BITS-1:0]   stg_mag   [NSTG+1];

   // Digit count stage
   logic                  len_valid_ff;
   logic                  len_neg_ff;
   logic [BCD_W-1:0]      len_bcd_ff;
   logic [POS_W-1:0]      len_top_ff;
   logic [POS_W-1:0]      len_top_in;
   logic [TOT_W-1:0]      len_total_ff;
   logic                  len_ready;

   // Character register
   logic                  out_busy_ff;
   logic                  out_minus_ff;
   logic [BCD_W-1:0]      out_bcd_ff;
   logic [POS_W-1:0]      out_pos_ff;
   logic [TOT_W-1:0]      out_total_ff;
   logic                  out_ready;
   logic                  out_take;
   logic [DIGIT_W-1:0]    out_digit;

   // Take the magnitude; the most negative value wraps to its unsigned form
   assign in0_abs   = req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;
   assign req_ready = !in0_valid_ff || stg_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in0_neg_ff <= req_value[VALUE_BITS-1];
         in0_mag_ff <= PAD_BITS'(in0_abs);
      end
   end

   assign stg_valid[0] = in0_valid_ff;
   assign stg_neg[0]   = in0_neg_ff;
   assign stg_bcd[0]   = '0;
   assign stg_mag[0]   = in0_mag_ff;

   // Binary to BCD, eight bits per stage
   for (genvar g = 0; g < NSTG; g++) begin : g_dabble
      sidta_dabble #(
         .NDIG     (NDIG),
         .PAD_BITS (PAD_BITS)
      ) u_dabble (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_ready  (stg_ready[g]),
         .in_neg    (stg_neg[g]),
         .in_bcd    (stg_bcd[g]),
         .in_mag    (stg_mag[g]),
         .out_valid (stg_valid[g+1]),
         .out_ready (stg_ready[g+1]),
         .out_neg   (stg_neg[g+1]),
         .out_bcd   (stg_bcd[g+1]),
         .out_mag   (stg_mag[g+1])
      );
   end

   // Find the most significant non-zero digit
   always_comb begin
      len_top_in = '0;
      for (int d = 0; d < NDIG; d++) begin
         if (stg_bcd[NSTG][d*DIGIT_W +: DIGIT_W] != '0) begin
            len_top_in = POS_W'(d);
         end
      end
   end

   assign len_ready        = !len_valid_ff || out_ready;
   assign stg_ready[NSTG]  = len_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= 1'b0;
      end else if (len_ready) begin
         len_valid_ff <= stg_valid[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (len_ready && stg_valid[NSTG]) begin
         len_neg_ff   <= stg_neg[NSTG];
         len_bcd_ff   <= stg_bcd[NSTG];
         len_top_ff   <= len_top_in;
         len_total_ff <= TOT_W'(len_top_in) + TOT_W'(1) + TOT_W'(stg_neg[NSTG]);
      end
   end

   // Emit the sign, then digits from the most significant down
   assign out_take  = rsp_valid && rsp_ready;
   assign out_ready = !out_busy_ff || (out_take && rsp_is_last);
   assign out_digit = out_bcd_ff[out_pos_ff*DIGIT_W +: DIGIT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_busy_ff  <= 1'b0;
         out_minus_ff <= 1'b0;
      end else if (out_ready) begin
         out_busy_ff  <= len_valid_ff;
         out_minus_ff <= len_valid_ff && len_neg_ff;
      end else if (out_take) begin
         out_minus_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && len_valid_ff) begin
         out_bcd_ff   <= len_bcd_ff;
         out_pos_ff   <= len_top_ff;
         out_total_ff <= len_total_ff;
      end else if (out_take && !out_minus_ff && out_pos_ff != '0) begin
         out_pos_ff <= out_pos_ff - 1'b1;
      end
   end

   assign rsp_valid       = out_busy_ff;
   assign rsp_char_code   = out_minus_ff ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(out_digit));
   assign rsp_text_length = LEN_W'(out_total_ff);
   assign rsp_is_last     = !out_minus_ff && (out_pos_ff == '0);

   // A run goes on after any character but the last
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_last |=> rsp_valid)
      else $error("character run broken before its last character");

   // The sign is never the final character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == ASCII_MINUS |-> !rsp_is_last)
      else $error("minus sign flagged as last character");

   // A sign is followed by a digit of the same run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_char_code == ASCII_MINUS |=>
         rsp_valid && rsp_char_code != ASCII_MINUS
         && rsp_text_length == $past(rsp_text_length))
      else $error("minus sign not followed by a digit of the same run");

   // Every character reports a non-empty run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_text_length != '0)
      else $error("character with zero run length");

endmodule

>>> rtl/core/sidta_dabble.sv
module sidta_dabble
   import sidta_pkg::*;
#(
   parameter int NDIG     = 10,
   parameter int PAD_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      in_neg,
   input  logic [NDIG*DIGIT_W-1:0]   in_bcd,
   input  logic [PAD_BITS-1:0]       in_mag,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic                      out_neg,
   output logic [NDIG*DIGIT_W-1:0]   out_bcd,
   output logic [PAD_BITS-1:0]       out_mag
);

   logic                    valid_ff;
   logic                    neg_ff;
   logic [NDIG*DIGIT_W-1:0] bcd_ff;
   logic [NDIG*DIGIT_W-1:0] bcd_in;
   logic [PAD_BITS-1:0]     mag_ff;
   logic [PAD_BITS-1:0]     mag_in;

   // Advance when the stage is empty or its request moves on
   assign in_ready = !valid_ff || out_ready;

   // Shift STEP_BITS magnitude bits into the BCD digits, add-3 before each shift
   always_comb begin
      bcd_in = in_bcd;
      mag_in = in_mag;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (bcd_in[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
               bcd_in[d*DIGIT_W +: DIGIT_W] = bcd_in[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
         end
         bcd_in = {bcd_in[NDIG*DIGIT_W-2:0], mag_in[PAD_BITS-1]};
         mag_in = {mag_in[PAD_BITS-2:0], 1'b0};
      end
   end

   // Hold the stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload on a new request
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         neg_ff <= in_neg;
         bcd_ff <= bcd_in;
         mag_ff <= mag_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_neg   = neg_ff;
   assign out_bcd   = bcd_ff;
   assign out_mag   = mag_ff;

endmodule
